@@ src/source_language_lexer_unit_macros.svh @@
// Assertion macros for the lexer RTL.
`ifndef SOURCE_LANGUAGE_LEXER_UNIT_MACROS_SVH
`define SOURCE_LANGUAGE_LEXER_UNIT_MACROS_SVH

// Same-cycle check: cond must hold on every clock edge outside reset.
`define SLU_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Next-cycle check: when trig holds, res must hold at the next clock edge.
`define SLU_CHECK_NEXT(lbl, trig, res, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (res)) else $error(msg);

`endif

@@ src/slu_pkg.sv @@
// Lexer package: mode and token codes, character constants, keyword tables.
package slu_pkg;

  // Lexer modes
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_DIGITS  = 4'd1;
  localparam logic [3:0] M_NAME    = 4'd2;
  localparam logic [3:0] M_COMMENT = 4'd3;
  localparam logic [3:0] M_EQ      = 4'd4;
  localparam logic [3:0] M_BANG    = 4'd5;
  localparam logic [3:0] M_REL     = 4'd6;
  localparam logic [3:0] M_AMP     = 4'd7;
  localparam logic [3:0] M_BAR     = 4'd8;

  // Token kinds
  localparam logic [3:0] K_DIGIT   = 4'd0;
  localparam logic [3:0] K_NAME    = 4'd1;
  localparam logic [3:0] K_OBRACE  = 4'd2;
  localparam logic [3:0] K_CBRACE  = 4'd3;
  localparam logic [3:0] K_SEMI    = 4'd4;
  localparam logic [3:0] K_ASSIGN  = 4'd5;
  localparam logic [3:0] K_OPER    = 4'd6;
  localparam logic [3:0] K_OPAREN  = 4'd7;
  localparam logic [3:0] K_CPAREN  = 4'd8;
  localparam logic [3:0] K_REL     = 4'd9;
  localparam logic [3:0] K_COND    = 4'd10;
  localparam logic [3:0] K_UNKNOWN = 4'd11;
  localparam logic [3:0] K_EOF     = 4'd12;

  localparam logic [3:0] KW_NONE   = 4'd0;
  localparam int         KW_COUNT  = 8;

  // Characters
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  // Keyword lengths, index 0 = procedure ... index 7 = read
  localparam logic [7:0][3:0] KW_LEN =
    {4'd4, 4'd4, 4'd5, 4'd5, 4'd4, 4'd4, 4'd2, 4'd9};

  // Handshake summary from the step logic to the result queue
  typedef struct packed {
    logic valid0;
    logic valid1;
  } step_ctl_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Character i of keyword k; zero past the end of the word.
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] i);
    logic [71:0] w;
    logic [3:0]  l;
    logic [3:0]  p;
    case (k)
      3'd0:    w = "procedure";
      3'd1:    w = "if";
      3'd2:    w = "then";
      3'd3:    w = "else";
      3'd4:    w = "while";
      3'd5:    w = "print";
      3'd6:    w = "call";
      default: w = "read";
    endcase
    l = KW_LEN[k];
    p = l - 4'd1 - i;
    if (i >= l) return 8'h00;
    return w[8*p +: 8];
  endfunction

endpackage

@@ src/slu_text_if.sv @@
// Input channel: one source byte or end marker per item.
interface slu_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_input;

  modport source (output valid, output text_byte, output end_of_input, input ready);
  modport sink (input valid, input text_byte, input end_of_input, output ready);
endinterface

@@ src/slu_token_if.sv @@
// Output channel: one token per item.
interface slu_token_if #(
  parameter int POS_W = 32,
  parameter int LEN_W = 16
);
  logic             valid;
  logic             ready;
  logic [3:0]       token_kind;
  logic [3:0]       keyword_code;
  logic [POS_W-1:0] start_position;
  logic [LEN_W-1:0] token_length;
  logic             length_saturated;
  logic             last_of_run;

  modport source (output valid, output token_kind, output keyword_code,
                  output start_position, output token_length,
                  output length_saturated, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input keyword_code,
                input start_position, input token_length,
                input length_saturated, input last_of_run, output ready);
endinterface

@@ src/source_language_lexer_unit.sv @@
// Streaming lexer top level: state registers, step logic and result queue.
//
//  channel   dir  item                                           handshake
//  text_in   in   text_byte, end_of_input                        valid/ready
//  token_out out  kind, keyword, start, length, saturated, last  valid/ready
//
// One byte is taken per cycle while text_in.ready is high; each byte yields
// zero, one or two tokens. Tokens sit in a four-entry queue; text_in.ready
// drops while fewer than two entries are free, so a byte that yields two
// tokens holds up the input only when token_out is stalled or the queue is
// backed up. Accepted tokens reach token_out from the queue, after older ones.
// rst (synchronous) empties the queue and returns the lexer to idle at offset 0.
`include "source_language_lexer_unit_macros.svh"

module source_language_lexer_unit #(
  parameter int POSITION_BITS = 32,
  parameter int LENGTH_BITS   = 16
) (
  input logic         clk,
  input logic         rst,
  slu_text_if.sink    text_in,
  slu_token_if.source token_out
);
  import slu_pkg::*;

  localparam int RES_W = 10 + POSITION_BITS + LENGTH_BITS;

  // lexer state
  logic [3:0]               lex_mode;
  logic [POSITION_BITS-1:0] token_start;
  logic [LENGTH_BITS-1:0]   run_length;
  logic [POSITION_BITS-1:0] stream_position;
  logic [7:0]               keyword_candidates;
  logic                     length_overflow;

  logic [3:0]               lex_mode_next;
  logic [POSITION_BITS-1:0] token_start_next;
  logic [LENGTH_BITS-1:0]   run_length_next;
  logic [POSITION_BITS-1:0] stream_position_next;
  logic [7:0]               keyword_candidates_next;
  logic                     length_overflow_next;

  logic [RES_W-1:0] res0, res1, q_data;
  step_ctl_t        ctl;
  logic             room;
  logic             accept;

  assign text_in.ready = room;
  assign accept        = text_in.valid && room;

  // Byte decode, flush of the pending token, classification of the byte
  slu_step #(
    .POS_W (POSITION_BITS),
    .LEN_W (LENGTH_BITS)
  ) u_step (
    .text_byte    (text_in.text_byte),
    .end_of_input (text_in.end_of_input),
    .mode         (lex_mode),
    .tok_start    (token_start),
    .run_len      (run_length),
    .pos          (stream_position),
    .cand         (keyword_candidates),
    .ovf          (length_overflow),
    .mode_next    (lex_mode_next),
    .start_next   (token_start_next),
    .len_next     (run_length_next),
    .pos_next     (stream_position_next),
    .cand_next    (keyword_candidates_next),
    .ovf_next     (length_overflow_next),
    .res0         (res0),
    .res1         (res1),
    .ctl          (ctl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode           <= M_IDLE;
      token_start        <= '0;
      run_length         <= '0;
      stream_position    <= '0;
      keyword_candidates <= '0;
      length_overflow    <= 1'b0;
    end else if (accept) begin
      lex_mode           <= lex_mode_next;
      token_start        <= token_start_next;
      run_length         <= run_length_next;
      stream_position    <= stream_position_next;
      keyword_candidates <= keyword_candidates_next;
      length_overflow    <= length_overflow_next;
    end
  end

  // Output side: tokens wait here so the input can keep moving while the queue has room
  slu_rq #(
    .DATA_W (RES_W)
  ) u_rq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .ctl       (ctl),
    .d0        (res0),
    .d1        (res1),
    .room      (room),
    .out_valid (token_out.valid),
    .out_ready (token_out.ready),
    .out_data  (q_data)
  );

  // {kind, keyword, start, length, saturated, last}
  assign token_out.token_kind       = q_data[RES_W-1 -: 4];
  assign token_out.keyword_code     = q_data[RES_W-5 -: 4];
  assign token_out.start_position   = q_data[LENGTH_BITS+2 +: POSITION_BITS];
  assign token_out.token_length     = q_data[2 +: LENGTH_BITS];
  assign token_out.length_saturated = q_data[1];
  assign token_out.last_of_run      = q_data[0];

  // keyword tracking only lives inside a name
  `SLU_CHECK(a_cand_only_in_name, (lex_mode == M_NAME) || (keyword_candidates == 8'h00),
             "keyword candidates outside a name")
  // overflow flag only once the length counter is pinned at its maximum
  `SLU_CHECK(a_ovf_at_max, !length_overflow || (run_length == '1),
             "length overflow with counter below maximum")
  // a queue with too little room for the input always has a token on offer
  `SLU_CHECK(a_stall_has_token, text_in.ready || token_out.valid,
             "input stalled with nothing to deliver")
  // end marker restarts the stream
  `SLU_CHECK_NEXT(a_eoi_restart, accept && text_in.end_of_input,
                  (stream_position == '0) && (lex_mode == M_IDLE),
                  "state not cleared after end marker")

endmodule

@@ src/slu_step.sv @@
// Lexer step: next state and up to two tokens for one input byte.
module slu_step #(
  parameter int POS_W = 32,
  parameter int LEN_W = 16,
  localparam int RES_W = 10 + POS_W + LEN_W
) (
  input  logic [7:0]       text_byte,
  input  logic             end_of_input,
  input  logic [3:0]       mode,
  input  logic [POS_W-1:0] tok_start,
  input  logic [LEN_W-1:0] run_len,
  input  logic [POS_W-1:0] pos,
  input  logic [7:0]       cand,
  input  logic             ovf,
  output logic [3:0]       mode_next,
  output logic [POS_W-1:0] start_next,
  output logic [LEN_W-1:0] len_next,
  output logic [POS_W-1:0] pos_next,
  output logic [7:0]       cand_next,
  output logic             ovf_next,
  output logic [RES_W-1:0] res0,
  output logic [RES_W-1:0] res1,
  output slu_pkg::step_ctl_t ctl
);
  import slu_pkg::*;

  // {kind, keyword, start, length, saturated, last}
  function automatic logic [RES_W-1:0] pack(input logic [3:0] kind, input logic [3:0] kw,
                                            input logic [POS_W-1:0] st,
                                            input logic [LEN_W-1:0] ln, input logic sat);
    return {kind, kw, st, ln, sat, 1'b0};
  endfunction

  logic [3:0]       kwc;
  logic [7:0]       first_mask;
  logic             fl_v;
  logic [RES_W-1:0] fl;
  logic             e0_v, e1_v, done, bgn;
  logic [RES_W-1:0] e0, e1;
  logic [3:0]       bgn_mode;

  // keyword of the pending name, lowest index wins
  always_comb begin
    kwc = KW_NONE;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (cand[k] && (run_len == LEN_W'(KW_LEN[k]))) kwc = 4'(k + 1);
    end
    if (ovf) kwc = KW_NONE;
  end

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      first_mask[k] = (kw_char(3'(k), 4'd0) == text_byte);
    end
  end

  // token held pending in the current mode
  always_comb begin
    fl_v = 1'b1;
    case (mode)
      M_DIGITS: fl = pack(K_DIGIT, KW_NONE, tok_start, run_len, ovf);
      M_NAME:   fl = pack(K_NAME, kwc, tok_start, run_len, ovf);
      M_EQ:     fl = pack(K_ASSIGN, KW_NONE, tok_start, LEN_W'(1), 1'b0);
      M_BANG:   fl = pack(K_COND, KW_NONE, tok_start, LEN_W'(1), 1'b0);
      M_REL:    fl = pack(K_REL, KW_NONE, tok_start, LEN_W'(1), 1'b0);
      M_AMP,
      M_BAR:    fl = pack(K_UNKNOWN, KW_NONE, tok_start, LEN_W'(1), 1'b0);
      default: begin
        fl_v = 1'b0;
        fl   = '0;
      end
    endcase
  end

  always_comb begin
    mode_next  = mode;
    start_next = tok_start;
    len_next   = run_len;
    pos_next   = pos + POS_W'(1);
    cand_next  = cand;
    ovf_next   = ovf;
    e0_v       = 1'b0;
    e0         = fl;
    e1_v       = 1'b0;
    e1         = '0;
    done       = 1'b0;
    bgn        = 1'b0;
    bgn_mode   = M_IDLE;

    if (end_of_input) begin
      e0_v       = fl_v;
      e1_v       = 1'b1;
      e1         = pack(K_EOF, KW_NONE, pos, '0, 1'b0);
      mode_next  = M_IDLE;
      start_next = '0;
      len_next   = '0;
      pos_next   = '0;
      cand_next  = '0;
      ovf_next   = 1'b0;
    end else begin
      case (mode)
        M_DIGITS: begin
          if (is_digit(text_byte)) begin
            done = 1'b1;
            if (run_len != '1) len_next = run_len + LEN_W'(1);
            else ovf_next = 1'b1;
          end else begin
            e0_v = 1'b1;
          end
        end
        M_NAME: begin
          if (is_digit(text_byte) || is_letter(text_byte)) begin
            done = 1'b1;
            for (int k = 0; k < KW_COUNT; k++) begin
              if (cand[k] && (ovf || (run_len >= LEN_W'(KW_LEN[k])) ||
                  (kw_char(3'(k), run_len[3:0]) != text_byte)))
                cand_next[k] = 1'b0;
            end
            if (run_len != '1) len_next = run_len + LEN_W'(1);
            else ovf_next = 1'b1;
          end else begin
            e0_v = 1'b1;
          end
        end
        M_COMMENT: begin
          if ((text_byte != CH_LF) && (text_byte != CH_CR)) done = 1'b1;
          else mode_next = M_IDLE;
        end
        M_EQ, M_BANG, M_REL: begin
          if (text_byte == CH_EQ) begin
            e0_v      = 1'b1;
            e0        = pack(K_REL, KW_NONE, tok_start, LEN_W'(2), 1'b0);
            mode_next = M_IDLE;
            done      = 1'b1;
          end else begin
            e0_v = 1'b1;
          end
        end
        M_AMP, M_BAR: begin
          if (text_byte == ((mode == M_AMP) ? CH_AMP : CH_BAR)) begin
            e0_v      = 1'b1;
            e0        = pack(K_COND, KW_NONE, tok_start, LEN_W'(2), 1'b0);
            mode_next = M_IDLE;
            done      = 1'b1;
          end else begin
            e0_v = 1'b1;
          end
        end
        default: mode_next = M_IDLE;
      endcase

      // pending token flushed: back to idle before classifying this byte
      if (!done && e0_v) begin
        mode_next = M_IDLE;
        cand_next = '0;
      end

      if (!done) begin
        if (is_digit(text_byte)) begin
          bgn      = 1'b1;
          bgn_mode = M_DIGITS;
        end else if (is_letter(text_byte)) begin
          bgn      = 1'b1;
          bgn_mode = M_NAME;
        end else if (!is_space(text_byte)) begin
          e1_v = 1'b1;
          case (text_byte)
            CH_BSLASH: begin
              e1_v      = 1'b0;
              mode_next = M_COMMENT;
            end
            CH_EQ: begin
              e1_v = 1'b0;
              bgn = 1'b1;
              bgn_mode = M_EQ;
            end
            CH_BANG: begin
              e1_v = 1'b0;
              bgn = 1'b1;
              bgn_mode = M_BANG;
            end
            CH_LT, CH_GT: begin
              e1_v = 1'b0;
              bgn = 1'b1;
              bgn_mode = M_REL;
            end
            CH_AMP: begin
              e1_v = 1'b0;
              bgn = 1'b1;
              bgn_mode = M_AMP;
            end
            CH_BAR: begin
              e1_v = 1'b0;
              bgn = 1'b1;
              bgn_mode = M_BAR;
            end
            CH_LBRACE: e1 = pack(K_OBRACE, KW_NONE, pos, LEN_W'(1), 1'b0);
            CH_RBRACE: e1 = pack(K_CBRACE, KW_NONE, pos, LEN_W'(1), 1'b0);
            CH_SEMI:   e1 = pack(K_SEMI, KW_NONE, pos, LEN_W'(1), 1'b0);
            CH_LPAREN: e1 = pack(K_OPAREN, KW_NONE, pos, LEN_W'(1), 1'b0);
            CH_RPAREN: e1 = pack(K_CPAREN, KW_NONE, pos, LEN_W'(1), 1'b0);
            CH_PLUS, CH_MINUS, CH_SLASH, CH_PCT, CH_STAR:
              e1 = pack(K_OPER, KW_NONE, pos, LEN_W'(1), 1'b0);
            default:   e1 = pack(K_UNKNOWN, KW_NONE, pos, LEN_W'(1), 1'b0);
          endcase
        end
      end

      if (bgn) begin
        mode_next  = bgn_mode;
        start_next = pos;
        len_next   = LEN_W'(1);
        ovf_next   = 1'b0;
        cand_next  = (bgn_mode == M_NAME) ? first_mask : 8'h00;
      end
    end

    // compact into slots; last flag on the final one
    ctl.valid0 = e0_v || e1_v;
    ctl.valid1 = e0_v && e1_v;
    res0       = e0_v ? e0 : e1;
    res1       = e1;
    if (ctl.valid1) res1[0] = 1'b1;
    else res0[0] = 1'b1;
  end

endmodule

@@ src/slu_rq.sv @@
// Result queue: four entries, takes up to two items per cycle while room is high, gives one when out_ready is high.
module slu_rq #(
  parameter int DATA_W = 58
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  slu_pkg::step_ctl_t ctl,
  input  logic [DATA_W-1:0] d0,
  input  logic [DATA_W-1:0] d1,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);
  import slu_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr, rd;
  logic [CNT_W-1:0]  count;
  logic [PTR_W-1:0]  wr1;
  logic [CNT_W-1:0]  n_push;
  logic              pop;

  assign wr1       = wr + PTR_W'(1);
  assign pop       = out_valid && out_ready;
  assign n_push    = push ? (CNT_W'(ctl.valid0) + CNT_W'(ctl.valid1)) : '0;
  assign room      = count <= CNT_W'(DEPTH - 2);
  assign out_valid = count != '0;
  assign out_data  = mem[rd];

  always_ff @(posedge clk) begin
    if (push && ctl.valid0) mem[wr] <= d0;
    if (push && ctl.valid1) mem[wr1] <= d1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + n_push[PTR_W-1:0];
      if (pop) rd <= rd + PTR_W'(1);
      count <= count + n_push - CNT_W'(pop);
    end
  end

endmodule

@@ tb/testbench.sv @@
// Testbench for source_language_lexer_unit: byte stimulus, token prediction and checking.
`timescale 1ns / 1ps

module testbench;
  import slu_pkg::*;

  localparam int POS_W = 32;
  localparam int LEN_W = 16;

  // Cycles with no item moving on either channel before the run is abandoned.
  // Worst correct case is a long receiver stall at 65% idling; this is many
  // times that.
  localparam int STALL_LIMIT = 2000;
  // Cycles allowed after the last expected token for stray extras to show up.
  localparam int DRAIN_CYCLES = 8;

  // Idling schedule: phase 0 sender 16% / receiver 65%, phase 1 the reverse,
  // phase 2 neither side idles.
  localparam int PHASE0_END = 250;
  localparam int PHASE1_END = 480;
  localparam int RANDOM_END = 700;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic [1:0] phase;
  } text_item_t;

  typedef struct packed {
    logic [3:0]       kind;
    logic [3:0]       kw;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             sat;
    logic             last;
  } token_t;

  logic clk = 1'b0;
  logic rst;

  slu_text_if text_ch ();
  slu_token_if #(.POS_W(POS_W), .LEN_W(LEN_W)) token_ch ();

  source_language_lexer_unit #(
    .POSITION_BITS(POS_W),
    .LENGTH_BITS  (LEN_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_ch),
    .token_out(token_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Lexer state as the predictor sees it
  // ---------------------------------------------------------------------------
  logic [3:0]       lex_mode;
  logic [POS_W-1:0] tok_start;
  logic [LEN_W-1:0] run_len;
  logic [POS_W-1:0] stream_pos;
  logic [7:0]       kw_cands;
  logic             len_ovf;

  token_t     step_tokens[$];      // tokens produced by the byte being predicted
  token_t     expected_tokens[$];  // tokens owed by the DUT, oldest first
  text_item_t text_items[$];       // bytes still to be driven

  int         items_total;
  int         items_taken = 0;
  int         error_count = 0;
  int         stall_cycles = 0;
  logic [1:0] drive_phase = 2'd0;
  logic [1:0] fill_phase;

  function automatic string keyword_text(input int k);
    case (k)
      0:       return "procedure";
      1:       return "if";
      2:       return "then";
      3:       return "else";
      4:       return "while";
      5:       return "print";
      6:       return "call";
      default: return "read";
    endcase
  endfunction

  function automatic logic digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic blank_char(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic token_t make_token(input logic [3:0] kind, input logic [3:0] kw,
                                        input logic [POS_W-1:0] start,
                                        input logic [LEN_W-1:0] len, input logic sat);
    token_t t;
    t.kind  = kind;
    t.kw    = kw;
    t.start = start;
    t.len   = len;
    t.sat   = sat;
    t.last  = 1'b0;
    return t;
  endfunction

  function automatic logic [3:0] name_keyword();
    string w;
    if (len_ovf) return KW_NONE;
    for (int k = 0; k < KW_COUNT; k++) begin
      w = keyword_text(k);
      if (kw_cands[k] && run_len == w.len()) return 4'(k + 1);
    end
    return KW_NONE;
  endfunction

  // Length counter sticks at all ones; the next byte past that flags overflow.
  task automatic grow_run();
    if (run_len != {LEN_W{1'b1}}) run_len = run_len + 1'b1;
    else len_ovf = 1'b1;
  endtask

  task automatic open_token(input logic [3:0] mode, input logic [7:0] c);
    string w;
    lex_mode  = mode;
    tok_start = stream_pos;
    run_len   = LEN_W'(1);
    len_ovf   = 1'b0;
    kw_cands  = '0;
    if (mode == M_NAME) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        w = keyword_text(k);
        if (w[0] == c) kw_cands[k] = 1'b1;
      end
    end
  endtask

  // Drop every keyword that no longer matches at this position, then count.
  task automatic extend_name(input logic [7:0] c);
    string w;
    int    pos;
    pos = int'(run_len);
    for (int k = 0; k < KW_COUNT; k++) begin
      w = keyword_text(k);
      if (kw_cands[k] && (len_ovf || pos >= w.len() || w[pos] != c)) kw_cands[k] = 1'b0;
    end
    grow_run();
  endtask

  task automatic add_step_token(input token_t t);
    step_tokens.insert(step_tokens.size(), t);
  endtask

  // Emit whatever token is held pending and go idle.
  task automatic flush_pending();
    case (lex_mode)
      M_DIGITS: add_step_token(make_token(K_DIGIT, KW_NONE, tok_start, run_len, len_ovf));
      M_NAME:
        add_step_token(make_token(K_NAME, name_keyword(), tok_start, run_len, len_ovf));
      M_EQ:     add_step_token(make_token(K_ASSIGN, KW_NONE, tok_start, LEN_W'(1), 1'b0));
      M_BANG:   add_step_token(make_token(K_COND, KW_NONE, tok_start, LEN_W'(1), 1'b0));
      M_REL:    add_step_token(make_token(K_REL, KW_NONE, tok_start, LEN_W'(1), 1'b0));
      M_AMP, M_BAR:
        add_step_token(make_token(K_UNKNOWN, KW_NONE, tok_start, LEN_W'(1), 1'b0));
      default: ;
    endcase
    lex_mode = M_IDLE;
    kw_cands = '0;
  endtask

  task automatic emit_single(input logic [3:0] kind);
    add_step_token(make_token(kind, KW_NONE, stream_pos, LEN_W'(1), 1'b0));
  endtask

  // A byte that the current mode did not consume is lexed from idle.
  task automatic lex_fresh(input logic [7:0] c);
    if (digit_char(c)) open_token(M_DIGITS, c);
    else if (letter_char(c)) open_token(M_NAME, c);
    else if (!blank_char(c)) begin
      case (c)
        CH_BSLASH: lex_mode = M_COMMENT;
        CH_EQ:     open_token(M_EQ, c);
        CH_BANG:   open_token(M_BANG, c);
        CH_LT, CH_GT: open_token(M_REL, c);
        CH_AMP:    open_token(M_AMP, c);
        CH_BAR:    open_token(M_BAR, c);
        CH_LBRACE: emit_single(K_OBRACE);
        CH_RBRACE: emit_single(K_CBRACE);
        CH_SEMI:   emit_single(K_SEMI);
        CH_LPAREN: emit_single(K_OPAREN);
        CH_RPAREN: emit_single(K_CPAREN);
        CH_PLUS, CH_MINUS, CH_SLASH, CH_PCT, CH_STAR: emit_single(K_OPER);
        default:   emit_single(K_UNKNOWN);
      endcase
    end
  endtask

  task automatic reset_lexer();
    lex_mode   = M_IDLE;
    tok_start  = '0;
    run_len    = '0;
    stream_pos = '0;
    kw_cands   = '0;
    len_ovf    = 1'b0;
  endtask

  // Predict the tokens of one accepted item and queue them as expected.
  task automatic lex_byte(input logic [7:0] c, input logic eoi);
    logic consumed;
    consumed = 1'b0;
    step_tokens.delete();
    if (eoi) begin
      flush_pending();
      add_step_token(make_token(K_EOF, KW_NONE, stream_pos, '0, 1'b0));
      reset_lexer();
    end else begin
      case (lex_mode)
        M_DIGITS:
          if (digit_char(c)) begin
            grow_run();
            consumed = 1'b1;
          end else flush_pending();
        M_NAME:
          if (digit_char(c) || letter_char(c)) begin
            extend_name(c);
            consumed = 1'b1;
          end else flush_pending();
        M_COMMENT:
          if (c != CH_LF && c != CH_CR) consumed = 1'b1;
          else lex_mode = M_IDLE;
        M_EQ, M_BANG, M_REL:
          if (c == CH_EQ) begin
            add_step_token(make_token(K_REL, KW_NONE, tok_start, LEN_W'(2), 1'b0));
            lex_mode = M_IDLE;
            consumed = 1'b1;
          end else flush_pending();
        M_AMP, M_BAR:
          if (c == (lex_mode == M_AMP ? CH_AMP : CH_BAR)) begin
            add_step_token(make_token(K_COND, KW_NONE, tok_start, LEN_W'(2), 1'b0));
            lex_mode = M_IDLE;
            consumed = 1'b1;
          end else flush_pending();
        default: lex_mode = M_IDLE;
      endcase
      if (!consumed) lex_fresh(c);
      stream_pos = stream_pos + 1'b1;
    end
    if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] c);
    text_items.insert(text_items.size(), '{ch: c, eoi: 1'b0, phase: fill_phase});
  endtask

  // End marker; the byte field carries junk since the block must ignore it.
  task automatic add_end();
    text_items.insert(text_items.size(),
                      '{ch: 8'($urandom_range(0, 255)), eoi: 1'b1, phase: fill_phase});
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic string punct_text(input int k);
    case (k)
      0:  return "{";
      1:  return "}";
      2:  return ";";
      3:  return "(";
      4:  return ")";
      5:  return "=";
      6:  return "==";
      7:  return "+";
      8:  return "-";
      9:  return "/";
      10: return "%";
      11: return "*";
      12: return "<";
      13: return ">";
      14: return "<=";
      15: return ">=";
      16: return "!";
      17: return "!=";
      18: return "&&";
      19: return "||";
      20: return "&";
      default: return "|";
    endcase
  endfunction

  function automatic logic [7:0] rand_alnum();
    case ($urandom_range(0, 2))
      0:       return 8'("0" + $urandom_range(0, 9));
      1:       return 8'("a" + $urandom_range(0, 25));
      default: return 8'("A" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25)) : 8'("A" + $urandom_range(0, 25));
  endfunction

  // One lexeme of a mostly well-formed program, with some noise mixed in.
  task automatic add_lexeme();
    string      w;
    int         pick;
    int         n;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 20) add_text(keyword_text($urandom_range(0, KW_COUNT - 1)));
    else if (pick < 28) begin
      // near misses: prefix, extension, or wrong case of a keyword
      w = keyword_text($urandom_range(0, KW_COUNT - 1));
      case ($urandom_range(0, 2))
        0: begin
          n = $urandom_range(1, w.len() - 1);
          for (int i = 0; i < n; i++) add_byte(w[i]);
        end
        1: begin
          add_text(w);
          add_byte(rand_alnum());
        end
        default: begin
          add_byte(w[0] - 8'd32);
          for (int i = 1; i < w.len(); i++) add_byte(w[i]);
        end
      endcase
    end else if (pick < 40) begin
      add_byte(rand_letter());
      n = $urandom_range(0, 7);
      repeat (n) add_byte(rand_alnum());
    end else if (pick < 50) begin
      n = $urandom_range(1, 6);
      repeat (n) add_byte(8'("0" + $urandom_range(0, 9)));
    end else if (pick < 72) add_text(punct_text($urandom_range(0, 21)));
    else if (pick < 80) begin
      // comment body may hold any byte but line ends; sometimes left open
      add_byte(CH_BSLASH);
      n = $urandom_range(0, 6);
      repeat (n) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR);
        add_byte(b);
      end
      case ($urandom_range(0, 4))
        0, 1:    add_byte(CH_LF);
        2, 3:    add_byte(CH_CR);
        default: ;
      endcase
    end else if (pick < 92) begin
      n = $urandom_range(1, 2);
      repeat (n) begin
        b = 8'($urandom_range(8, 13));
        add_byte(b == 8'd8 ? 8'h20 : b);
      end
    end else add_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic int sender_idle_pct(input logic [1:0] phase);
    return phase == 2'd0 ? 16 : phase == 2'd1 ? 65 : 0;
  endfunction

  function automatic int receiver_idle_pct(input logic [1:0] phase);
    return phase == 2'd0 ? 65 : phase == 2'd1 ? 16 : 0;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 100) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want, input logic [31:0] at);
    if (got !== want)
      report_error($sformatf("token at offset %0d: %s is %0d, expected %0d",
                             at, field, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued bytes, predicts each one as it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_text
    text_item_t nxt;
    if (rst) begin
      text_ch.valid        <= 1'b0;
      text_ch.text_byte    <= 8'h00;
      text_ch.end_of_input <= 1'b0;
    end else begin
      if (text_ch.valid && text_ch.ready) begin
        lex_byte(text_ch.text_byte, text_ch.end_of_input);
        items_taken <= items_taken + 1;
      end
      // a held item stays up until taken; otherwise load the next or idle
      if (!text_ch.valid || text_ch.ready) begin
        if (text_items.size() != 0 &&
            $urandom_range(0, 99) >= sender_idle_pct(text_items[0].phase)) begin
          nxt = text_items.pop_front();
          text_ch.valid        <= 1'b1;
          text_ch.text_byte    <= nxt.ch;
          text_ch.end_of_input <= nxt.eoi;
          drive_phase          <= nxt.phase;
        end else begin
          text_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes tokens with random back-pressure, checks against the oldest
  // expected token
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_tokens
    token_t got;
    token_t want;
    if (rst) begin
      token_ch.ready <= 1'b0;
    end else begin
      if (token_ch.valid && token_ch.ready) begin
        got.kind  = token_ch.token_kind;
        got.kw    = token_ch.keyword_code;
        got.start = token_ch.start_position;
        got.len   = token_ch.token_length;
        got.sat   = token_ch.length_saturated;
        got.last  = token_ch.last_of_run;
        if (expected_tokens.size() == 0) begin
          report_error($sformatf("token kind %0d at offset %0d with none expected",
                                 got.kind, got.start));
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_kind", 32'(got.kind), 32'(want.kind), 32'(want.start));
          check_field("keyword_code", 32'(got.kw), 32'(want.kw), 32'(want.start));
          check_field("start_position", 32'(got.start), 32'(want.start), 32'(want.start));
          check_field("token_length", 32'(got.len), 32'(want.len), 32'(want.start));
          check_field("length_saturated", 32'(got.sat), 32'(want.sat), 32'(want.start));
          check_field("last_of_run", 32'(got.last), 32'(want.last), 32'(want.start));
        end
      end
      token_ch.ready <= $urandom_range(0, 99) >= receiver_idle_pct(drive_phase);
    end
  end

  // Watchdog: give up when neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (token_ch.valid && token_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    rst = 1'b1;
    reset_lexer();

    // Directed text: relationals, both two-byte conditionals, '!' and '!=',
    // NUL and 0xFF as unknowns, a lone '&' and a lone '|' each followed by
    // a different byte, and a comment holding a high byte that runs into
    // the end marker.
    fill_phase = 2'd0;
    add_text("if(p1<=9&&!x||y!=2)");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_AMP);
    add_byte(CH_BAR);
    add_byte(CH_BSLASH);
    add_byte(8'hFF);
    add_end();

    // Random programs, each closed by an end marker so that offsets restart.
    while (text_items.size() < RANDOM_END) begin
      fill_phase = text_items.size() < PHASE0_END ? 2'd0 :
                   text_items.size() < PHASE1_END ? 2'd1 : 2'd2;
      n = $urandom_range(0, 30);
      repeat (n) add_lexeme();
      add_end();
    end
    items_total = text_items.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // wait for every byte to be taken, then for every owed token
    while (items_taken != items_total) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    // leave room for stray tokens behind the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
